// ===== hdl/mouse_gesture_recognizer_defines.svh =====
// ----------------------------------------------------------------------------
// Mouse gesture recognizer assertion macros
// Shared property wrappers, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MOUSE_GESTURE_RECOGNIZER_DEFINES_SVH
`define MOUSE_GESTURE_RECOGNIZER_DEFINES_SVH

// same-cycle implication
`define MGR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MGR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mgr_pkg.sv =====
// ----------------------------------------------------------------------------
// Mouse gesture recognizer package
// Word types, command and gesture codes, fixed widths.
// ----------------------------------------------------------------------------
package mgr_pkg;

	localparam int ENTRY_W   = 30;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] CMD_DOWN = 2'd0;
	localparam logic [1:0] CMD_UP   = 2'd1;
	localparam logic [1:0] CMD_MOVE = 2'd2;

	localparam logic [2:0] GT_NONE   = 3'd0;
	localparam logic [2:0] GT_LEFT   = 3'd1;
	localparam logic [2:0] GT_RIGHT  = 3'd2;
	localparam logic [2:0] GT_UP     = 3'd3;
	localparam logic [2:0] GT_DOWN   = 3'd4;
	localparam logic [2:0] GT_SCROLL = 3'd5;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_ACTION = 2'd1;
	localparam logic [1:0] KIND_SCROLL = 2'd2;

	// 30 * 30
	localparam logic [32:0] MIN_D2 = 33'd900;
	// ceil(2^18 / 5): exact quotient for 17-bit magnitudes
	localparam logic [15:0] RECIP5 = 16'd52429;

	typedef struct packed {
		logic [7:0]  action;
		logic [15:0] thr;
		logic [2:0]  gtype;
		logic [2:0]  button;
	} entry_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [2:0]         button;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
	} ev_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         action_code;
		logic signed [15:0] scroll_x;
		logic signed [15:0] scroll_y;
		logic               suppress;
	} res_t;

endpackage

// ===== hdl/mouse_gesture_recognizer.sv =====
// ----------------------------------------------------------------------------
// Mouse gesture recognizer
// Tracks a trigger button and turns pointer moves into swipe actions or
// divide-by-five scroll steps, per a small table of gesture entries.
// ----------------------------------------------------------------------------
//  port group  dir  handshake            word
//  ev          in   ev_valid / ev_stall  ev_t  (cmd, button, pos_x, pos_y)
//  res         out  res_valid / res_stall res_t (kind, action, scroll, suppress)
//  cfg         in   cfg_valid / cfg_ready cfg_index, cfg_data (entry word)
//
//  One word per cycle sustained unless a full result register is stalled;
//  words pass the input register, then the result register; the entry scan,
//  squares and divide by five all sit between them, closing the state loop.
//  Squared thresholds are formed when an entry is written.
//  arst_n clears gesture state and all entries to zero.
//  ev_stall rises only when the input register holds a word and the result
//  register is full and stalled.
// ----------------------------------------------------------------------------
`include "mouse_gesture_recognizer_defines.svh"

module mouse_gesture_recognizer
	import mgr_pkg::*;
#(
	parameter int ENTRY_COUNT = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ev_valid,
	output logic                 ev_stall,
	input  ev_t                  ev,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ENTRY_W-1:0]   cfg_data
);

	// ---------------- entry table ----------------
	entry_t      entry_q  [ENTRY_COUNT];
	logic [31:0] thr_sq_q [ENTRY_COUNT];
	entry_t      cfg_entry;
	logic [31:0] cfg_thr_sq;

	assign cfg_ready  = 1'b1;
	assign cfg_entry  = entry_t'(cfg_data);
	assign cfg_thr_sq = 32'(cfg_entry.thr) * 32'(cfg_entry.thr);

	for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_entry
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				entry_q[g]  <= '0;
				thr_sq_q[g] <= '0;
			end else if (cfg_valid && cfg_ready && cfg_index == CFG_IDX_W'(g)) begin
				entry_q[g]  <= cfg_entry;
				thr_sq_q[g] <= cfg_thr_sq;
			end
		end
	end

	// ---------------- input register ----------------
	ev_t  ev_s1;
	logic valid_s1;
	logic adv;
	logic step;
	logic res_valid_q;
	res_t res_q;

	assign adv      = !res_valid_q || !res_stall;
	assign ev_stall = valid_s1 && !adv;
	assign step     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!ev_stall) begin
			valid_s1 <= ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid && !ev_stall) begin
			ev_s1 <= ev;
		end
	end

	// ---------------- gesture state ----------------
	logic [2:0]         active_q, active_d;
	logic signed [15:0] start_x_q, start_y_q, start_x_d, start_y_d;
	logic signed [15:0] last_x_q, last_y_q, last_x_d, last_y_d;
	logic               fired_q, fired_d;
	logic               scroll_q, scroll_d;
	// remainders never leave -4..4
	logic signed [3:0]  rem_x_q, rem_y_q, rem_x_d, rem_y_d;
	res_t               res_d;

	// signed divide by five, truncating; returns {quotient[15:0], remainder[3:0]}
	function automatic logic [19:0] div5(input logic signed [17:0] a);
		logic [17:0] neg_a;
		logic [16:0] mag;
		logic [32:0] prod;
		logic [14:0] q;
		logic [16:0] q5;
		logic [16:0] r;
		logic [15:0] qe;
		logic [3:0]  re;
		neg_a = -a;
		mag   = a[17] ? neg_a[16:0] : a[16:0];
		prod  = 33'(mag) * 33'(RECIP5);
		q     = prod[32:18];
		q5    = {q, 2'b00} + 17'(q);
		r     = mag - q5;
		qe    = {1'b0, q};
		re    = {1'b0, r[2:0]};
		if (a[17]) begin
			qe = 16'd0 - qe;
			re = 4'd0 - re;
		end
		return {qe, re};
	endfunction

	// geometry from the start point and from the last point
	logic signed [16:0] dx, dy, mx, my;
	logic [16:0]        ndx, ndy;
	logic [15:0]        adx, ady;
	logic [32:0]        d2;
	logic [2:0]         gest;
	logic signed [17:0] acc_x, acc_y;
	logic [19:0]        dv_x, dv_y;
	logic               has_entry;

	assign dx  = $signed({ev_s1.pos_x[15], ev_s1.pos_x}) - $signed({start_x_q[15], start_x_q});
	assign dy  = $signed({ev_s1.pos_y[15], ev_s1.pos_y}) - $signed({start_y_q[15], start_y_q});
	assign mx  = $signed({ev_s1.pos_x[15], ev_s1.pos_x}) - $signed({last_x_q[15], last_x_q});
	assign my  = $signed({ev_s1.pos_y[15], ev_s1.pos_y}) - $signed({last_y_q[15], last_y_q});
	assign ndx = -dx;
	assign ndy = -dy;
	assign adx = dx[16] ? ndx[15:0] : dx[15:0];
	assign ady = dy[16] ? ndy[15:0] : dy[15:0];
	assign d2  = 33'(32'(adx) * 32'(adx)) + 33'(32'(ady) * 32'(ady));

	always_comb begin
		if (d2 < MIN_D2) begin
			gest = GT_NONE;
		end else if (adx > ady) begin
			gest = dx[16] ? GT_LEFT : GT_RIGHT;
		end else begin
			gest = (!dy[16] && dy != '0) ? GT_DOWN : GT_UP;
		end
	end

	assign acc_x = $signed({mx[16], mx}) + $signed({{14{rem_x_q[3]}}, rem_x_q});
	assign acc_y = $signed({my[16], my}) + $signed({{14{rem_y_q[3]}}, rem_y_q});
	assign dv_x  = div5(acc_x);
	assign dv_y  = div5(acc_y);

	always_comb begin
		has_entry = 1'b0;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			if (entry_q[i].button != '0 && entry_q[i].button == ev_s1.button) begin
				has_entry = 1'b1;
			end
		end
	end

	// first matching entry wins
	logic       hit_scroll, hit_fire, done;
	logic [7:0] hit_action;

	always_comb begin
		hit_scroll = 1'b0;
		hit_fire   = 1'b0;
		done       = 1'b0;
		hit_action = '0;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			if (!done && entry_q[i].button != '0 && entry_q[i].button == active_q) begin
				if (entry_q[i].gtype == GT_SCROLL) begin
					hit_scroll = 1'b1;
					done       = 1'b1;
				end else if (!fired_q && d2 >= {1'b0, thr_sq_q[i]} &&
				             gest != GT_NONE && gest == entry_q[i].gtype) begin
					hit_fire   = 1'b1;
					hit_action = entry_q[i].action;
					done       = 1'b1;
				end
			end
		end
	end

	always_comb begin
		active_d  = active_q;
		start_x_d = start_x_q;
		start_y_d = start_y_q;
		last_x_d  = last_x_q;
		last_y_d  = last_y_q;
		fired_d   = fired_q;
		scroll_d  = scroll_q;
		rem_x_d   = rem_x_q;
		rem_y_d   = rem_y_q;
		res_d     = '0;
		case (ev_s1.cmd)
			CMD_DOWN: begin
				if (has_entry) begin
					active_d       = ev_s1.button;
					start_x_d      = ev_s1.pos_x;
					start_y_d      = ev_s1.pos_y;
					last_x_d       = ev_s1.pos_x;
					last_y_d       = ev_s1.pos_y;
					fired_d        = 1'b0;
					scroll_d       = 1'b0;
					rem_x_d        = '0;
					rem_y_d        = '0;
					res_d.suppress = 1'b1;
				end
			end
			CMD_UP: begin
				if (ev_s1.button == active_q) begin
					res_d.suppress = fired_q || scroll_q;
					active_d       = '0;
					fired_d        = 1'b0;
					scroll_d       = 1'b0;
				end
			end
			CMD_MOVE: begin
				if (active_q != '0) begin
					last_x_d = ev_s1.pos_x;
					last_y_d = ev_s1.pos_y;
					if (!fired_q || scroll_q) begin
						if (hit_scroll) begin
							scroll_d = 1'b1;
							rem_x_d  = $signed(dv_x[3:0]);
							rem_y_d  = $signed(dv_y[3:0]);
							if (dv_x[19:4] != '0 || dv_y[19:4] != '0) begin
								res_d.kind     = KIND_SCROLL;
								res_d.scroll_x = $signed(dv_x[19:4]);
								res_d.scroll_y = $signed(dv_y[19:4]);
							end
						end else if (hit_fire) begin
							fired_d           = 1'b1;
							res_d.kind        = KIND_ACTION;
							res_d.action_code = hit_action;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			fired_q   <= 1'b0;
			scroll_q  <= 1'b0;
			rem_x_q   <= '0;
			rem_y_q   <= '0;
		end else if (step) begin
			active_q  <= active_d;
			start_x_q <= start_x_d;
			start_y_q <= start_y_d;
			last_x_q  <= last_x_d;
			last_y_q  <= last_y_d;
			fired_q   <= fired_d;
			scroll_q  <= scroll_d;
			rem_x_q   <= rem_x_d;
			rem_y_q   <= rem_y_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---------------- checks ----------------
	`MGR_ASSERT_NOW(a_idle_clean, active_q == '0, !fired_q && !scroll_q, "flags set with no trigger")
	`MGR_ASSERT_NOW(a_rem_range, 1'b1, rem_x_q >= -4 && rem_x_q <= 4 && rem_y_q >= -4 && rem_y_q <= 4, "scroll remainder out of range")
	`MGR_ASSERT_NEXT(a_fired_quiet, step && fired_q && !scroll_q, res_q.kind == KIND_NONE, "result after swipe already fired")
	`MGR_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(ev_s1), "input register lost a word")

endmodule

// ===== sim/gesture_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture recognizer result checker
// Watches the config, event and result channels, keeps its own copy of the
// gesture entries and trigger state, predicts one result word per accepted
// event word and compares each result field with the oldest prediction.
// ----------------------------------------------------------------------------
module gesture_checker
	import mgr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ev_valid,
	input  logic                 ev_stall,
	input  ev_t                  ev,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  res_t                 res,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ENTRY_W-1:0]   cfg_data,
	output int                   errors,
	output int                   pending
);

	localparam int N_ENTRIES = 4;
	localparam int MIN_DIST  = 30;
	localparam int STEP_DIV  = 5;

	entry_t     gest_tbl [N_ENTRIES];
	logic [2:0] trig_btn;
	int         start_x, start_y, last_x, last_y;
	bit         fired, scroll_mode;
	int         rem_x, rem_y;
	res_t       expected_res [$];

	function automatic logic signed [15:0] sat16(input int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// next result word for one event word; advances the trigger state
	function automatic res_t gesture_outcome(input ev_t w);
		res_t       o;
		int         px, py, mx, my, ax, ay, qx, qy;
		longint     dx, dy, adx, ady, d2, thr2;
		logic [2:0] dir;
		bit         hit;
		o = '0;
		px = w.pos_x;
		py = w.pos_y;
		case (w.cmd)
		CMD_DOWN: begin
			hit = 1'b0;
			foreach (gest_tbl[i])
				if (gest_tbl[i].button != 3'd0 && gest_tbl[i].button == w.button)
					hit = 1'b1;
			if (hit) begin
				trig_btn = w.button;
				start_x = px;
				start_y = py;
				last_x = px;
				last_y = py;
				fired = 1'b0;
				scroll_mode = 1'b0;
				rem_x = 0;
				rem_y = 0;
				o.suppress = 1'b1;
			end
		end
		CMD_UP: begin
			if (w.button == trig_btn) begin
				o.suppress = fired | scroll_mode;
				trig_btn = 3'd0;
				fired = 1'b0;
				scroll_mode = 1'b0;
			end
		end
		CMD_MOVE: begin
			if (trig_btn != 3'd0) begin
				dx = longint'(px) - longint'(start_x);
				dy = longint'(py) - longint'(start_y);
				d2 = dx * dx + dy * dy;
				adx = (dx < 0) ? -dx : dx;
				ady = (dy < 0) ? -dy : dy;
				mx = px - last_x;
				my = py - last_y;
				last_x = px;
				last_y = py;
				if (!fired || scroll_mode) begin
					for (int i = 0; i < N_ENTRIES; i++) begin
						if (gest_tbl[i].button == 3'd0 || gest_tbl[i].button != trig_btn)
							continue;
						if (gest_tbl[i].gtype == GT_SCROLL) begin
							ax = rem_x + mx;
							ay = rem_y + my;
							// SV division truncates toward zero
							qx = ax / STEP_DIV;
							qy = ay / STEP_DIV;
							scroll_mode = 1'b1;
							if (qx != 0 || qy != 0) begin
								o.kind = KIND_SCROLL;
								o.scroll_x = sat16(qx);
								o.scroll_y = sat16(qy);
								ax -= qx * STEP_DIV;
								ay -= qy * STEP_DIV;
							end
							rem_x = ax;
							rem_y = ay;
							break;
						end
						thr2 = longint'(gest_tbl[i].thr) * longint'(gest_tbl[i].thr);
						if (!fired && d2 >= thr2 && d2 >= MIN_DIST * MIN_DIST) begin
							if (adx > ady)
								dir = (dx > 0) ? GT_RIGHT : GT_LEFT;
							else
								dir = (dy > 0) ? GT_DOWN : GT_UP;
							if (dir == gest_tbl[i].gtype) begin
								fired = 1'b1;
								o.kind = KIND_ACTION;
								o.action_code = gest_tbl[i].action;
								break;
							end
						end
					end
				end
			end
		end
		default: ;
		endcase
		return o;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			foreach (gest_tbl[i])
				gest_tbl[i] = '0;
			trig_btn = 3'd0;
			start_x = 0;
			start_y = 0;
			last_x = 0;
			last_y = 0;
			fired = 1'b0;
			scroll_mode = 1'b0;
			rem_x = 0;
			rem_y = 0;
			expected_res.delete();
			pending = 0;
		end else begin
			// out-of-range indexes leave the entries alone
			if (cfg_valid && cfg_ready && cfg_index < N_ENTRIES)
				gest_tbl[cfg_index] = entry_t'(cfg_data);
			if (ev_valid && !ev_stall)
				expected_res.push_back(gesture_outcome(ev));
			if (res_valid && !res_stall) begin
				if (expected_res.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result word kind %0d action %0h sx %0d sy %0d sup %0d",
							$time, res.kind, res.action_code, res.scroll_x, res.scroll_y,
							res.suppress);
				end else begin
					want = expected_res.pop_front();
					if (res.kind !== want.kind || res.action_code !== want.action_code ||
							res.scroll_x !== want.scroll_x || res.scroll_y !== want.scroll_y ||
							res.suppress !== want.suppress) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: result mismatch exp/got: kind %0d/%0d action %0h/%0h",
								" sx %0d/%0d sy %0d/%0d sup %0d/%0d"}, $time,
								want.kind, res.kind, want.action_code, res.action_code,
								want.scroll_x, res.scroll_x, want.scroll_y, res.scroll_y,
								want.suppress, res.suppress);
					end
				end
			end
			pending = expected_res.size();
		end
	end

endmodule

// ===== sim/mouse_gesture_recognizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mouse gesture recognizer testbench
// Directed button/move sequences, then randomized press-move-release
// gestures with noise over several entry tables, with random sender gaps,
// receiver stalls and one long receiver hold-off. Checking is done by
// gesture_checker.
// ----------------------------------------------------------------------------
module mouse_gesture_recognizer_tb
	import mgr_pkg::*;
();

	localparam int     HALF_PERIOD = 10;
	localparam int     LONG_HOLD   = 250;
	// run limit in ns; the clock period is 20 ns
	localparam longint RUN_LIMIT   = 64'd8_000_000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 ev_valid  = 1'b0;
	logic                 ev_stall;
	ev_t                  ev        = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ENTRY_W-1:0]   cfg_data  = '0;
	int                   errors;
	int                   pending;

	int         idle_pct    = 0;
	int         stall_pct   = 0;
	logic       hold_on     = 1'b0;
	logic       pressure_on = 1'b0;
	int         sent        = 0;
	int         cur_x       = 0;
	int         cur_y       = 0;
	entry_t     phase_tbl [4];

	mouse_gesture_recognizer #(
		.ENTRY_COUNT(4)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.ev_valid(ev_valid),
		.ev_stall(ev_stall),
		.ev(ev),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	gesture_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.ev_valid(ev_valid),
		.ev_stall(ev_stall),
		.ev(ev),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		res_stall <= hold_on || ($urandom_range(99) < stall_pct);
	end

	// long receiver hold-off so the block fills and stalls its input
	initial begin : rx_hold
		wait (pressure_on);
		repeat (5) @(posedge clk);
		hold_on <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin : watchdog
		#(RUN_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	function automatic int clip16(input int v);
		return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(65535)) - 32768;
	endfunction

	function automatic int spread(input int s);
		return int'($urandom_range(2 * s)) - s;
	endfunction

	function automatic void random_table(output entry_t t [4]);
		foreach (t[i]) begin
			case ($urandom_range(9))
			0:       t[i].button = 3'd0;
			1, 2:    t[i].button = 3'($urandom_range(7, 4));
			default: t[i].button = 3'($urandom_range(3, 1));
			endcase
			if ($urandom_range(9) == 0)
				t[i].gtype = 3'($urandom_range(7));
			else
				t[i].gtype = 3'($urandom_range(GT_SCROLL, GT_LEFT));
			t[i].thr = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(120));
			t[i].action = 8'($urandom());
		end
	endfunction

	task automatic send_ev(input logic [1:0] op, input logic [2:0] btn, input int x, input int y);
		ev <= ev_t'{cmd: op, button: btn, pos_x: x[15:0], pos_y: y[15:0]};
		ev_valid <= 1'b1;
		@(posedge clk);
		while (ev_stall)
			@(posedge clk);
		sent++;
		if ($urandom_range(99) < idle_pct) begin
			ev_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	// stop sending and let every expected word come back
	task automatic drain();
		ev_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_entries(input entry_t t [4], input bit stray);
		for (int i = 0; i < 4 + int'(stray); i++) begin
			cfg_index <= (i < 4) ? CFG_IDX_W'(i) : CFG_IDX_W'($urandom_range(7, 4));
			cfg_data <= (i < 4) ? ENTRY_W'(t[i]) : ENTRY_W'($urandom());
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// press, a run of drifting moves, release
	task automatic random_gesture();
		logic [2:0] btn;
		int         bx, by, n, s;
		btn = phase_tbl[$urandom_range(3)].button;
		if ($urandom_range(9) == 0)
			btn = 3'($urandom_range(7));
		if ($urandom_range(7) == 0) begin
			cur_x = any_coord();
			cur_y = any_coord();
		end
		bx = spread(15);
		by = spread(15);
		n = $urandom_range(12, 1);
		send_ev(CMD_DOWN, btn, cur_x, cur_y);
		repeat (n) begin
			if ($urandom_range(15) == 0) begin
				cur_x = any_coord();
				cur_y = any_coord();
			end else begin
				s = ($urandom_range(5) == 0) ? 300 : 6;
				cur_x = clip16(cur_x + bx + spread(s));
				cur_y = clip16(cur_y + by + spread(s));
			end
			if ($urandom_range(24) == 0)
				send_ev(CMD_DOWN, phase_tbl[$urandom_range(3)].button, cur_x, cur_y);
			send_ev(CMD_MOVE, 3'($urandom_range(7)), cur_x, cur_y);
		end
		if ($urandom_range(5) == 0)
			send_ev(CMD_UP, 3'($urandom_range(7)), cur_x, cur_y);
		else
			send_ev(CMD_UP, btn, cur_x, cur_y);
	endtask

	task automatic run_phase(input int idle, input int stall, input int goal);
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < goal) begin
			if ($urandom_range(6) == 0)
				send_ev(2'($urandom_range(3)), 3'($urandom_range(7)), any_coord(), any_coord());
			else
				random_gesture();
		end
		drain();
	endtask

	initial begin : stimulus
		entry_t dir_tbl [4];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// entries still cleared: nothing matches
		send_ev(CMD_DOWN, 3'd1, 5, 5);
		send_ev(CMD_MOVE, 3'd1, 90, 5);
		drain();

		dir_tbl[0] = '{action: 8'ha5, thr: 16'd0, gtype: GT_RIGHT, button: 3'd1};
		dir_tbl[1] = '{action: 8'h3c, thr: 16'd0, gtype: GT_SCROLL, button: 3'd2};
		dir_tbl[2] = '{action: 8'hff, thr: 16'hffff, gtype: GT_LEFT, button: 3'd1};
		dir_tbl[3] = '{action: 8'h01, thr: 16'd40, gtype: GT_DOWN, button: 3'd7};
		write_entries(dir_tbl, 1'b0);

		send_ev(2'd3, 3'd5, -32768, 32767);          // unknown command
		send_ev(CMD_MOVE, 3'd1, 100, 100);           // move with no trigger
		send_ev(CMD_DOWN, 3'd3, 0, 0);               // button without entry
		send_ev(CMD_DOWN, 3'd6, 0, 0);
		send_ev(CMD_DOWN, 3'd1, 0, 0);
		send_ev(CMD_MOVE, 3'd0, 10, 10);             // below minimum distance
		send_ev(CMD_MOVE, 3'd0, -40, 0);             // left, but threshold too big
		send_ev(CMD_MOVE, 3'd0, 40, 5);              // right swipe fires
		send_ev(CMD_MOVE, 3'd0, 100, 0);             // already fired
		send_ev(CMD_UP, 3'd2, 100, 0);               // other button
		send_ev(CMD_UP, 3'd1, 100, 0);
		send_ev(CMD_DOWN, 3'd2, 32767, -32768);
		send_ev(CMD_MOVE, 3'd2, 32764, -32761);      // one scroll step down
		send_ev(CMD_MOVE, 3'd2, 32766, -32760);      // no whole step
		send_ev(CMD_MOVE, 3'd2, -32768, 32767);      // full-scale jump
		send_ev(CMD_MOVE, 3'd2, -32763, 32760);
		send_ev(CMD_UP, 3'd2, 0, 0);
		send_ev(CMD_DOWN, 3'd7, 0, 0);
		send_ev(CMD_MOVE, 3'd7, 0, 45);              // down swipe past threshold
		send_ev(CMD_DOWN, 3'd1, 0, 0);               // restart with another button
		send_ev(CMD_MOVE, 3'd1, 0, -50);
		send_ev(CMD_DOWN, 3'd0, 0, 0);
		send_ev(CMD_UP, 3'd0, 0, 0);
		send_ev(CMD_UP, 3'd1, 0, 0);
		send_ev(CMD_MOVE, 3'd7, 32767, 32767);
		drain();

		foreach (phase_tbl[i])
			phase_tbl[i] = '1;
		write_entries(phase_tbl, 1'b0);
		run_phase(20, 20, 30);

		random_table(phase_tbl);
		write_entries(phase_tbl, 1'b0);
		run_phase(0, 0, 260);

		random_table(phase_tbl);
		write_entries(phase_tbl, 1'b1);
		run_phase(46, 0, 260);

		random_table(phase_tbl);
		write_entries(phase_tbl, 1'b0);
		run_phase(0, 46, 260);

		random_table(phase_tbl);
		write_entries(phase_tbl, 1'b0);
		run_phase(36, 36, 260);

		random_table(phase_tbl);
		write_entries(phase_tbl, 1'b0);
		pressure_on <= 1'b1;
		run_phase(0, 0, 80);

		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
